### hw/rtl/htse_pkg.sv
package htse_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_RESIZE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_STATIC    = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd3;

   localparam logic [16:0] ENTRY_OVERHEAD = 17'd32;
   localparam logic [15:0] RESET_CAPACITY = 16'd4096;

   typedef struct packed {
      logic        shift;
      logic        load;
      logic [15:0] load_size;
   } chain_ctl_type;

endpackage

### hw/rtl/htse_cell.sv
module htse_cell (
   input  logic                    clock,
   input  htse_pkg::chain_ctl_type ctl,
   input  logic                    here_wr,
   input  logic                    here_rd,
   input  logic [15:0]             next_size,
   output logic [15:0]             size,
   output logic [15:0]             rd_data
);

   logic [15:0] size_ff;
   logic [15:0] size_in;
   logic [15:0] rd_ff;

   always_comb begin
      size_in = size_ff;
      if (ctl.load && here_wr) begin
         size_in = ctl.load_size;
      end else if (ctl.shift) begin
         size_in = next_size;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      rd_ff   <= here_rd ? size_ff : '0;
   end

   assign size    = size_ff;
   assign rd_data = rd_ff;

endmodule

### hw/rtl/htse_chain.sv
module htse_chain #(
   parameter int NUM_CELLS = 2,
   localparam int PW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1
) (
   input  logic                    clock,
   input  htse_pkg::chain_ctl_type ctl,
   input  logic [PW-1:0]           wr_pos,
   input  logic [PW-1:0]           rd_pos,
   output logic [15:0]             head_size,
   output logic [15:0]             rd_data
);

   // Cell zero holds the oldest entry; an eviction moves every entry one cell down.
   logic [15:0] size_w [NUM_CELLS+1];
   logic [15:0] cell_rd [NUM_CELLS];
   logic [15:0] rd_in;
   logic [15:0] rd_ff;

   assign size_w[NUM_CELLS] = '0;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      htse_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .here_wr   (wr_pos == PW'(k)),
         .here_rd   (rd_pos == PW'(k)),
         .next_size (size_w[k+1]),
         .size      (size_w[k]),
         .rd_data   (cell_rd[k])
      );
   end

   always_comb begin
      rd_in = '0;
      for (int k = 0; k < NUM_CELLS; k++) begin
         rd_in = rd_in | cell_rd[k];
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
   end

   assign head_size = size_w[0];
   assign rd_data   = rd_ff;

endmodule

### hw/rtl/header_table_size_evictor.sv
// Flow: a lookup hit passes through LOOK1 and LOOK2, which cover the registered read path of the
// cell chain, to DONE; an insert passes through EVICT, which shifts the chain one entry per cycle
// while an eviction is needed, then through INSERT to DONE; a size update passes through EVICT to
// DONE; an oversized insert or any other request goes straight to DONE, where the response is
// loaded once the output is free. A response still waiting on the output delays the next one.
// A new request is taken only after the response to the last one is loaded.
// Reset clears the table to empty and loads the capacity with 4096; stored sizes are not cleared.
module header_table_size_evictor #(
   parameter int MAX_ENTRIES  = 128,
   parameter int STATIC_COUNT = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_entry_len,
   input  logic [15:0] req_new_max,
   input  logic [7:0]  req_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_slot,
   output logic [15:0] rsp_entry_size,
   output logic [7:0]  rsp_evicted,
   output logic [6:0]  rsp_oldest_slot,
   output logic [7:0]  rsp_entry_count,
   output logic [15:0] rsp_table_octets,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int PW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int DW = (CW > 8) ? CW : 8;
   localparam int SW = DW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_INSERT,
      ST_LOOK1,
      ST_LOOK2,
      ST_DONE
   } state_type;

   state_type   state_ff;
   logic [PW-1:0] newest_ff;
   logic [PW-1:0] oldest_ff;
   logic [CW-1:0] count_ff;
   logic [15:0]   total_ff;
   logic [15:0]   capacity_ff;
   logic          size_updated_ff;

   logic [1:0]    func_ff;
   logic [15:0]   need_ff;
   logic [15:0]   lim_ff;
   logic [CW-1:0] evict_cnt_ff;
   logic [PW-1:0] first_ff;
   logic [1:0]    status_ff;
   logic [PW-1:0] slot_ff;
   logic [15:0]   esize_ff;
   logic          hit_ff;
   logic [PW-1:0] rd_pos_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_slot_ff;
   logic [15:0]   rsp_entry_size_ff;
   logic [7:0]    rsp_evicted_ff;
   logic [6:0]    rsp_oldest_slot_ff;
   logic [7:0]    rsp_entry_count_ff;
   logic [15:0]   rsp_table_octets_ff;

   logic [16:0]   need_in;
   logic [PW-1:0] newest_inc;
   logic [PW-1:0] oldest_inc;
   logic          idle_evict;
   logic          evict_need;
   logic          rsp_load;
   logic [7:0]    look_d;
   logic [DW-1:0] look_d_dw;
   logic [SW-1:0] newest_sw;
   logic [SW-1:0] look_d_sw;
   logic [PW-1:0] look_slot;
   logic [PW-1:0] look_pos;
   logic [15:0]   head_size;
   logic [15:0]   chain_rd;
   htse_pkg::chain_ctl_type chain_ctl;

   assign need_in    = 17'(req_entry_len) + htse_pkg::ENTRY_OVERHEAD;
   assign newest_inc = (newest_ff == PW'(MAX_ENTRIES - 1)) ? '0 : newest_ff + PW'(1);
   assign oldest_inc = (oldest_ff == PW'(MAX_ENTRIES - 1)) ? '0 : oldest_ff + PW'(1);
   assign idle_evict = (count_ff != '0) && (total_ff > capacity_ff);
   assign evict_need = ((count_ff != '0) && (total_ff > lim_ff)) ||
                       ((func_ff == htse_pkg::FUNC_INSERT) && (count_ff == CW'(MAX_ENTRIES)));
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign look_d    = req_index - 8'(STATIC_COUNT);
   assign look_d_dw = DW'(look_d);
   assign newest_sw = SW'(newest_ff);
   assign look_d_sw = SW'(look_d);
   assign look_slot = (newest_sw >= look_d_sw) ? PW'(newest_sw - look_d_sw)
                                              : PW'(newest_sw + SW'(MAX_ENTRIES) - look_d_sw);
   assign look_pos  = PW'(DW'(count_ff) - DW'(1) - look_d_dw);

   assign req_ready = (state_ff == ST_IDLE) && !idle_evict && !csr_wr_en;

   always_comb begin
      chain_ctl.shift     = ((state_ff == ST_IDLE) && idle_evict) ||
                            ((state_ff == ST_EVICT) && evict_need);
      chain_ctl.load      = (state_ff == ST_INSERT);
      chain_ctl.load_size = need_ff;
   end

   htse_chain #(
      .NUM_CELLS (MAX_ENTRIES)
   ) u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .wr_pos    (PW'(count_ff)),
      .rd_pos    (rd_pos_ff),
      .head_size (head_size),
      .rd_data   (chain_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         newest_ff       <= '0;
         oldest_ff       <= '0;
         count_ff        <= '0;
         total_ff        <= '0;
         capacity_ff     <= htse_pkg::RESET_CAPACITY;
         size_updated_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en && !size_updated_ff) begin
            capacity_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  func_ff <= req_func;
                  case (req_func)
                     htse_pkg::FUNC_INSERT: begin
                        hit_ff <= 1'b0;
                        if (need_in > {1'b0, capacity_ff}) begin
                           status_ff    <= htse_pkg::STATUS_TOO_LARGE;
                           evict_cnt_ff <= count_ff;
                           first_ff     <= (count_ff == '0) ? '0 : oldest_ff;
                           slot_ff      <= '0;
                           esize_ff     <= '0;
                           count_ff     <= '0;
                           total_ff     <= '0;
                           oldest_ff    <= newest_ff;
                           state_ff     <= ST_DONE;
                        end else begin
                           status_ff    <= htse_pkg::STATUS_DONE;
                           evict_cnt_ff <= '0;
                           first_ff     <= '0;
                           need_ff      <= need_in[15:0];
                           lim_ff       <= capacity_ff - need_in[15:0];
                           state_ff     <= ST_EVICT;
                        end
                     end
                     htse_pkg::FUNC_RESIZE: begin
                        status_ff       <= htse_pkg::STATUS_DONE;
                        evict_cnt_ff    <= '0;
                        first_ff        <= '0;
                        slot_ff         <= '0;
                        esize_ff        <= '0;
                        hit_ff          <= 1'b0;
                        capacity_ff     <= req_new_max;
                        size_updated_ff <= 1'b1;
                        lim_ff          <= req_new_max;
                        state_ff        <= ST_EVICT;
                     end
                     htse_pkg::FUNC_LOOKUP: begin
                        evict_cnt_ff <= '0;
                        first_ff     <= '0;
                        esize_ff     <= '0;
                        if (req_index == '0) begin
                           status_ff <= htse_pkg::STATUS_RANGE;
                           hit_ff    <= 1'b0;
                           slot_ff   <= '0;
                           state_ff  <= ST_DONE;
                        end else if (req_index < 8'(STATIC_COUNT)) begin
                           status_ff <= htse_pkg::STATUS_STATIC;
                           hit_ff    <= 1'b0;
                           slot_ff   <= '0;
                           state_ff  <= ST_DONE;
                        end else if (look_d_dw >= DW'(count_ff)) begin
                           status_ff <= htse_pkg::STATUS_RANGE;
                           hit_ff    <= 1'b0;
                           slot_ff   <= '0;
                           state_ff  <= ST_DONE;
                        end else begin
                           status_ff <= htse_pkg::STATUS_DONE;
                           hit_ff    <= 1'b1;
                           slot_ff   <= look_slot;
                           rd_pos_ff <= look_pos;
                           state_ff  <= ST_LOOK1;
                        end
                     end
                     default: begin
                        status_ff    <= htse_pkg::STATUS_DONE;
                        evict_cnt_ff <= '0;
                        first_ff     <= '0;
                        slot_ff      <= '0;
                        esize_ff     <= '0;
                        hit_ff       <= 1'b0;
                        state_ff     <= ST_DONE;
                     end
                  endcase
               end else if (idle_evict) begin
                  total_ff  <= total_ff - head_size;
                  count_ff  <= count_ff - CW'(1);
                  oldest_ff <= (count_ff == CW'(1)) ? newest_ff : oldest_inc;
               end
            end
            ST_EVICT: begin
               if (evict_need) begin
                  total_ff     <= total_ff - head_size;
                  count_ff     <= count_ff - CW'(1);
                  oldest_ff    <= (count_ff == CW'(1)) ? newest_ff : oldest_inc;
                  evict_cnt_ff <= evict_cnt_ff + CW'(1);
                  if (evict_cnt_ff == '0) begin
                     first_ff <= oldest_ff;
                  end
               end else if (func_ff == htse_pkg::FUNC_INSERT) begin
                  state_ff <= ST_INSERT;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_INSERT: begin
               newest_ff <= newest_inc;
               if (count_ff == '0) begin
                  oldest_ff <= newest_inc;
               end
               count_ff <= count_ff + CW'(1);
               total_ff <= total_ff + need_ff;
               slot_ff  <= newest_inc;
               esize_ff <= need_ff;
               state_ff <= ST_DONE;
            end
            ST_LOOK1: begin
               state_ff <= ST_LOOK2;
            end
            ST_LOOK2: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_status_ff       <= status_ff;
                  rsp_slot_ff         <= 7'(slot_ff);
                  rsp_entry_size_ff   <= hit_ff ? chain_rd : esize_ff;
                  rsp_evicted_ff      <= 8'(evict_cnt_ff);
                  rsp_oldest_slot_ff  <= 7'(first_ff);
                  rsp_entry_count_ff  <= 8'(count_ff);
                  rsp_table_octets_ff <= total_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_entry_size   = rsp_entry_size_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_oldest_slot  = rsp_oldest_slot_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_table_octets = rsp_table_octets_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("Entry count exceeds the table depth.");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (total_ff == '0))
      else $error("Empty table reports a nonzero size.");

   a_fits_at_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (total_ff <= capacity_ff))
      else $error("Table size exceeds capacity when the request completes.");

   a_room_on_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (count_ff < CW'(MAX_ENTRIES)))
      else $error("Insert into a full ring.");

endmodule
